/* sv/scs_pkg.sv */
// Shared types and constants for the span context stack.
// Depends on nothing; every other file but scs_ram refers to it by scoped names.
`default_nettype none
package scs_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DROP_MAX    = 63;
   localparam int DEPTH_MAX   = 127;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_EMIT  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_VALID = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_THI   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_TLO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_SPAN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_FLAGS = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] span_id;
      logic [7:0]  span_flags;
      logic [63:0] trace_id_hi;
      logic [63:0] trace_id_lo;
   } req_type;

   typedef struct packed {
      logic        ctx_valid;
      logic [63:0] ctx_trace_hi;
      logic [63:0] ctx_trace_lo;
      logic [63:0] ctx_span;
      logic [7:0]  ctx_flags;
      logic        pushed;
      logic        found;
      logic [5:0]  dropped_above;
      logic [6:0]  depth;
   } rsp_type;

   typedef struct packed {
      logic [63:0] span;
      logic [7:0]  flags;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_TOP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_top;
      logic scan_rd;
      logic hit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_func;
      logic       count_zero;
      logic       idx_zero;
      logic       match;
      logic       out_free;
   } status_type;

endpackage
`default_nettype wire

/* sv/scs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module scs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/scs_ctrl.sv */
// Sequencer for the span context stack: dispatches push, emit and query.
// Depends on scs_pkg.
`default_nettype none
module scs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire scs_pkg::status_type status,
   output scs_pkg::cmd_type         cmd
);

   scs_pkg::state_type state_ff;
   scs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.in_func == scs_pkg::FUNC_PUSH ||
                   status.in_func == scs_pkg::FUNC_QUERY) begin
                  state_in = status.count_zero ? scs_pkg::ST_FINISH : scs_pkg::ST_RD_TOP;
               end else if (status.in_func == scs_pkg::FUNC_EMIT) begin
                  state_in = status.count_zero ? scs_pkg::ST_FINISH : scs_pkg::ST_SCAN_RD;
               end else begin
                  state_in = scs_pkg::ST_FINISH;
               end
            end
         end
         scs_pkg::ST_RD_TOP:  state_in = scs_pkg::ST_FINISH;
         scs_pkg::ST_SCAN_RD: state_in = scs_pkg::ST_SCAN_CMP;
         scs_pkg::ST_SCAN_CMP: begin
            if (status.match || status.idx_zero) begin
               state_in = scs_pkg::ST_FINISH;
            end else begin
               state_in = scs_pkg::ST_SCAN_RD;
            end
         end
         scs_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = scs_pkg::ST_IDLE;
            end
         end
         default: state_in = scs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         scs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         scs_pkg::ST_RD_TOP:   cmd.rd_top  = 1'b1;
         scs_pkg::ST_SCAN_RD:  cmd.scan_rd = 1'b1;
         scs_pkg::ST_SCAN_CMP: cmd.hit     = status.match;
         scs_pkg::ST_FINISH:   cmd.finish  = status.out_free;
         default: cmd = '0;
      endcase
   end

   // a compare step always follows its read step
   assert property (@(posedge clock) disable iff (reset)
      state_ff == scs_pkg::ST_SCAN_CMP |-> $past(state_ff) == scs_pkg::ST_SCAN_RD)
      else $error("compare without read");

   // an accepted request always moves the sequencer out of idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != scs_pkg::ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // leaving the finish step always loads the response register
   assert property (@(posedge clock) disable iff (reset)
      state_ff == scs_pkg::ST_FINISH && state_in == scs_pkg::ST_IDLE |-> cmd.finish)
      else $error("finish left without loading response");

endmodule
`default_nettype wire

/* sv/scs_dp.sv */
// Datapath: root context registers, entry RAM, stack count, scan index
// and response register. Depends on scs_pkg and scs_ram.
`default_nettype none
module scs_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire scs_pkg::req_type                  req_data,
   output scs_pkg::rsp_type                       rsp_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic                              csr_valid,
   input  wire logic [scs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [63:0]                       csr_wdata,
   input  wire scs_pkg::cmd_type                  cmd,
   output scs_pkg::status_type                    status
);

   localparam int CW = scs_pkg::CNT_W;
   localparam int PW = scs_pkg::PTR_W;

   logic        root_valid_ff;
   logic [63:0] root_thi_ff;
   logic [63:0] root_tlo_ff;
   logic [63:0] root_span_ff;
   logic [7:0]  root_flags_ff;

   scs_pkg::req_type   req_ff;
   scs_pkg::rsp_type   rsp_ff;
   scs_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      idx_ff;
   logic               found_ff;
   logic [CW-1:0]      rd_sel;
   logic [CW-1:0]      drop_cnt;
   scs_pkg::entry_type top_entry;
   scs_pkg::entry_type wr_entry;
   logic               full;
   logic               wr_en;
   logic               has_top;

   // root context registers
   always_ff @(posedge clock) begin
      if (reset) begin
         root_valid_ff <= 1'b0;
         root_thi_ff   <= '0;
         root_tlo_ff   <= '0;
         root_span_ff  <= '0;
         root_flags_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            scs_pkg::CSR_ROOT_VALID: root_valid_ff <= csr_wdata[0];
            scs_pkg::CSR_ROOT_THI:   root_thi_ff   <= csr_wdata;
            scs_pkg::CSR_ROOT_TLO:   root_tlo_ff   <= csr_wdata;
            scs_pkg::CSR_ROOT_SPAN:  root_span_ff  <= csr_wdata;
            scs_pkg::CSR_ROOT_FLAGS: root_flags_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign full    = count_ff == CW'(scs_pkg::STACK_DEPTH);
   assign has_top = count_ff != '0;
   assign wr_en   = cmd.finish && req_ff.func == scs_pkg::FUNC_PUSH && !full;
   assign rd_sel  = cmd.rd_top ? count_ff - CW'(1) : idx_ff - CW'(1);

   assign wr_entry.span  = req_ff.span_id;
   assign wr_entry.flags = rsp_in.ctx_flags;

   scs_ram #(
      .WIDTH ($bits(scs_pkg::entry_type)),
      .DEPTH (scs_pkg::STACK_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[PW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_top || cmd.scan_rd),
      .rd_addr (rd_sel[PW-1:0]),
      .rd_data (top_entry)
   );

   // idx_ff holds the entry just read during a scan
   assign drop_cnt = count_ff - CW'(1) - idx_ff;

   always_comb begin
      rsp_in   = '0;
      count_in = count_ff;
      case (req_ff.func)
         scs_pkg::FUNC_PUSH: begin
            if (has_top) begin
               rsp_in.ctx_valid    = 1'b1;
               rsp_in.ctx_trace_hi = root_valid_ff ? root_thi_ff : req_ff.trace_id_hi;
               rsp_in.ctx_trace_lo = root_valid_ff ? root_tlo_ff : req_ff.trace_id_lo;
               rsp_in.ctx_span     = top_entry.span;
               rsp_in.ctx_flags    = top_entry.flags;
            end else if (root_valid_ff) begin
               rsp_in.ctx_valid    = 1'b1;
               rsp_in.ctx_trace_hi = root_thi_ff;
               rsp_in.ctx_trace_lo = root_tlo_ff;
               rsp_in.ctx_span     = root_span_ff;
               rsp_in.ctx_flags    = root_flags_ff;
            end else begin
               rsp_in.ctx_trace_hi = req_ff.trace_id_hi;
               rsp_in.ctx_trace_lo = req_ff.trace_id_lo;
               rsp_in.ctx_flags    = req_ff.span_flags;
            end
            if (!full) begin
               rsp_in.pushed = 1'b1;
               count_in      = count_ff + CW'(1);
            end
         end
         scs_pkg::FUNC_EMIT: begin
            if (found_ff) begin
               rsp_in.found         = 1'b1;
               rsp_in.dropped_above = (32'(drop_cnt) > 32'(scs_pkg::DROP_MAX)) ?
                                      6'(scs_pkg::DROP_MAX) : 6'(drop_cnt);
               count_in             = idx_ff;
            end
         end
         scs_pkg::FUNC_QUERY: begin
            if (has_top) begin
               rsp_in.ctx_valid    = 1'b1;
               rsp_in.ctx_trace_hi = root_valid_ff ? root_thi_ff : 64'd0;
               rsp_in.ctx_trace_lo = root_valid_ff ? root_tlo_ff : 64'd0;
               rsp_in.ctx_span     = top_entry.span;
               rsp_in.ctx_flags    = top_entry.flags;
            end else if (root_valid_ff) begin
               rsp_in.ctx_valid    = 1'b1;
               rsp_in.ctx_trace_hi = root_thi_ff;
               rsp_in.ctx_trace_lo = root_tlo_ff;
               rsp_in.ctx_span     = root_span_ff;
               rsp_in.ctx_flags    = root_flags_ff;
            end
         end
         default: ;
      endcase
      rsp_in.depth = (32'(count_in) > 32'(scs_pkg::DEPTH_MAX)) ?
                     7'(scs_pkg::DEPTH_MAX) : 7'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff   <= count_ff;
            found_ff <= 1'b0;
         end else if (cmd.scan_rd) begin
            idx_ff <= idx_ff - CW'(1);
         end else if (cmd.hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.in_func    = req_data.func;
   assign status.count_zero = !has_top;
   assign status.idx_zero   = idx_ff == '0;
   assign status.match      = top_entry.span == req_ff.span_id;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(scs_pkg::STACK_DEPTH))
      else $error("stack count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff)
      else $error("scan index above stack top");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + CW'(1))
      else $error("stored push did not advance the count");

endmodule
`default_nettype wire

/* sv/span_context_stack.sv */
// Span context stack: a bounded stack of span ids and flags with a
// configured root trace context. A request is taken only while the block
// is idle; a push or query reads the top entry from the entry RAM in its
// read step, skipped when the stack is empty, then loads the response in
// its finish step. An emit walks the stack from the top down, a RAM read
// step then a compare step per entry examined; a miss walks the whole
// stack. Func 3 and operations on an empty stack go straight to the
// finish step. The response sits in an output register; the next request
// is taken once the current one is loaded there, and a stalled response
// holds the block in its finish step only when a second response is ready
// behind it. Root registers (index 0..4: valid, trace hi, trace lo, span,
// flags) are written through the csr_ port; the user must write them only
// while the block is idle, which the block itself does not enforce;
// csr_ready is always high. Stack entries need no clearing after reset.
// Depends on scs_pkg, scs_ctrl, scs_dp and scs_ram.
`default_nettype none
module span_context_stack (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire scs_pkg::req_type              req_data,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output scs_pkg::rsp_type                   rsp_data,
   // root context register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [scs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                   csr_wdata
);

   scs_pkg::cmd_type    cmd;
   scs_pkg::status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: decides which step runs each cycle
   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: holds the request, stack, root context and response
   scs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for span_context_stack: directed and random push, emit and
// query requests against a cycle-free prediction of the stack and root context.
// Depends on scs_pkg and the span_context_stack RTL.
`default_nettype none
module testbench;

   localparam logic [1:0] FUNC_SPARE      = 2'd3;    // unused selector, answers depth only
   localparam int         N_PHASES        = 8;
   localparam int         ITEMS_PER_PHASE = 160;
   localparam int         DRAIN_CYCLES    = 2 * scs_pkg::STACK_DEPTH + 12;  // full-stack miss
   localparam int         LIMIT_CYCLES    = 2_000_000;

   typedef enum int {ROOT_OFF, ROOT_ONES, ROOT_ZEROS, ROOT_RANDOM} root_setting_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   scs_pkg::req_type              req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   scs_pkg::rsp_type              rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [scs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                   csr_wdata = '0;

   span_context_stack DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting for the driver, and the ids the stack will hold once they are done.
   // The second list only steers emits toward ids that are really on the stack.
   scs_pkg::req_type req_backlog[$];
   logic [63:0]      planned_ids[$];

   // Predicted copy of the block: root registers, stack entries and depth.
   logic             root_on;
   logic [63:0]      root_thi, root_tlo, root_sid;
   logic [7:0]       root_flg;
   logic [63:0]      stack_span [scs_pkg::STACK_DEPTH];
   logic [7:0]       stack_flags[scs_pkg::STACK_DEPTH];
   int               stack_n;
   scs_pkg::rsp_type expected_ctx_q[$];

   int   n_queued, n_accepted, n_answered;
   int   n_refused, n_missed, n_found, n_settings;
   int   fail_count;
   int   cycles;
   logic req_fire  = 1'b0;
   logic idle_on   = 1'b1;
   int   send_gap  = 0;
   int   rdy_left  = 0;
   logic rdy_level = 1'b1;

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly random, with the two extremes showing up now and then.
   function automatic logic [63:0] trace_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return rand_word();
   endfunction

   function automatic int draw_gap();
      int pick;
      if (!idle_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------------------
   // Prediction: advance the stack copy by one request and return the context it reports.
   // ---------------------------------------------------------------------------------
   task automatic apply_span_op(input scs_pkg::req_type rq, output scs_pkg::rsp_type ctx);
      int i;
      int hit;
      int n_above;
      ctx = '0;
      case (rq.func)
         scs_pkg::FUNC_PUSH: begin
            if (stack_n > 0) begin
               // parent is the top entry; trace id still prefers the root
               ctx.ctx_valid    = 1'b1;
               ctx.ctx_trace_hi = root_on ? root_thi : rq.trace_id_hi;
               ctx.ctx_trace_lo = root_on ? root_tlo : rq.trace_id_lo;
               ctx.ctx_span     = stack_span[stack_n - 1];
               ctx.ctx_flags    = stack_flags[stack_n - 1];
            end else if (root_on) begin
               ctx.ctx_valid    = 1'b1;
               ctx.ctx_trace_hi = root_thi;
               ctx.ctx_trace_lo = root_tlo;
               ctx.ctx_span     = root_sid;
               ctx.ctx_flags    = root_flg;
            end else begin
               // no parent at all: echo the caller's trace id and flags
               ctx.ctx_trace_hi = rq.trace_id_hi;
               ctx.ctx_trace_lo = rq.trace_id_lo;
               ctx.ctx_flags    = rq.span_flags;
            end
            if (stack_n < scs_pkg::STACK_DEPTH) begin
               stack_span[stack_n]  = rq.span_id;
               stack_flags[stack_n] = ctx.ctx_flags;
               stack_n++;
               ctx.pushed = 1'b1;
            end else begin
               n_refused++;
            end
         end
         scs_pkg::FUNC_EMIT: begin
            // search from the top down and pop to and including the first match
            hit = -1;
            for (i = stack_n - 1; i >= 0 && hit < 0; i--)
               if (stack_span[i] == rq.span_id) hit = i;
            if (hit >= 0) begin
               n_above           = stack_n - 1 - hit;
               ctx.found         = 1'b1;
               ctx.dropped_above = 6'((n_above > scs_pkg::DROP_MAX) ?
                                      scs_pkg::DROP_MAX : n_above);
               stack_n           = hit;
               n_found++;
            end else begin
               n_missed++;
            end
         end
         scs_pkg::FUNC_QUERY: begin
            if (stack_n > 0) begin
               ctx.ctx_valid    = 1'b1;
               ctx.ctx_trace_hi = root_on ? root_thi : '0;
               ctx.ctx_trace_lo = root_on ? root_tlo : '0;
               ctx.ctx_span     = stack_span[stack_n - 1];
               ctx.ctx_flags    = stack_flags[stack_n - 1];
            end else if (root_on) begin
               ctx.ctx_valid    = 1'b1;
               ctx.ctx_trace_hi = root_thi;
               ctx.ctx_trace_lo = root_tlo;
               ctx.ctx_span     = root_sid;
               ctx.ctx_flags    = root_flg;
            end
         end
         default: ;
      endcase
      ctx.depth = 7'((stack_n > scs_pkg::DEPTH_MAX) ? scs_pkg::DEPTH_MAX : stack_n);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Monitor: track register writes, score responses, predict accepted requests.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      scs_pkg::rsp_type want;
      scs_pkg::rsp_type pred;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               scs_pkg::CSR_ROOT_VALID: root_on  = csr_wdata[0];
               scs_pkg::CSR_ROOT_THI:   root_thi = csr_wdata;
               scs_pkg::CSR_ROOT_TLO:   root_tlo = csr_wdata;
               scs_pkg::CSR_ROOT_SPAN:  root_sid = csr_wdata;
               scs_pkg::CSR_ROOT_FLAGS: root_flg = csr_wdata[7:0];
               default: ;
            endcase
         end
         // score the response first: it can never belong to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            n_answered++;
            if (expected_ctx_q.size() == 0) begin
               $error("response arrived with no request outstanding");
               fail_count++;
            end else begin
               want = expected_ctx_q.pop_front();
               check_field("ctx_valid",     64'(want.ctx_valid),
                           64'(rsp_data.ctx_valid));
               check_field("ctx_trace_hi",  want.ctx_trace_hi,  rsp_data.ctx_trace_hi);
               check_field("ctx_trace_lo",  want.ctx_trace_lo,  rsp_data.ctx_trace_lo);
               check_field("ctx_span",      want.ctx_span,      rsp_data.ctx_span);
               check_field("ctx_flags",     64'(want.ctx_flags),
                           64'(rsp_data.ctx_flags));
               check_field("pushed",        64'(want.pushed),   64'(rsp_data.pushed));
               check_field("found",         64'(want.found),    64'(rsp_data.found));
               check_field("dropped_above", 64'(want.dropped_above),
                           64'(rsp_data.dropped_above));
               check_field("depth",         64'(want.depth),    64'(rsp_data.depth));
            end
         end
         if (req_valid && req_ready) begin
            n_accepted++;
            apply_span_op(req_data, pred);
            expected_ctx_q.push_back(pred);
         end
      end
      req_fire <= !reset && req_valid && req_ready;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycles, n_queued - n_answered);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Request driver: hold each request until accepted, then idle for its drawn gap.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      logic             nxt_valid;
      scs_pkg::req_type nxt_data;
      nxt_valid = req_valid;
      nxt_data  = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && req_fire) nxt_valid = 1'b0;
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (req_backlog.size() > 0) begin
               nxt_data  = req_backlog.pop_front();
               nxt_valid = 1'b1;
               send_gap  = draw_gap();
            end
         end
      end
      // one assignment per signal per edge, so a held valid never blips
      req_valid <= nxt_valid;
      req_data  <= nxt_data;
   end

   // Response back-pressure: runs of ready, short stalls and the odd long one.
   always @(negedge clock) begin : drive_rsp_ready
      int pick;
      if (rdy_left == 0) begin
         pick = $urandom_range(0, 99);
         if (!idle_on || pick < 55) begin
            rdy_level = 1'b1;
            rdy_left  = $urandom_range(1, 12);
         end else if (pick < 93) begin
            rdy_level = 1'b0;
            rdy_left  = $urandom_range(1, 3);
         end else begin
            rdy_level = 1'b0;
            rdy_left  = $urandom_range(15, 60);
         end
      end
      rdy_left--;
      rsp_ready <= rdy_level;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   // Queue one request and advance the planned stack contents the same way.
   task automatic queue_request(input logic [1:0] op, input logic [63:0] id,
                                input logic [7:0] flags, input logic [63:0] thi,
                                input logic [63:0] tlo);
      scs_pkg::req_type rq;
      int               i;
      int               hit;
      rq.func        = op;
      rq.span_id     = id;
      rq.span_flags  = flags;
      rq.trace_id_hi = thi;
      rq.trace_id_lo = tlo;
      req_backlog.push_back(rq);
      n_queued++;
      if (op == scs_pkg::FUNC_PUSH && planned_ids.size() < scs_pkg::STACK_DEPTH) begin
         planned_ids.push_back(id);
      end else if (op == scs_pkg::FUNC_EMIT) begin
         hit = -1;
         for (i = planned_ids.size() - 1; i >= 0 && hit < 0; i--)
            if (planned_ids[i] == id) hit = i;
         if (hit >= 0)
            while (planned_ids.size() > hit) void'(planned_ids.pop_back());
      end
   endtask

   // Emit ids: mostly the top, sometimes a few below it, rarely anything or a miss.
   function automatic logic [63:0] pick_emit_id();
      int pick;
      int n;
      int n_back;
      n    = planned_ids.size();
      pick = $urandom_range(0, 99);
      if (n == 0 || pick < 10) return rand_word();
      if (pick < 70)      n_back = 0;
      else if (pick < 90) n_back = $urandom_range(1, 3);
      else                n_back = $urandom_range(0, n - 1);
      if (n_back > n - 1) n_back = n - 1;
      return planned_ids[n - 1 - n_back];
   endfunction

   // Push ids: fresh, with an occasional duplicate of one already stacked.
   function automatic logic [63:0] pick_push_id();
      if (planned_ids.size() > 0 && $urandom_range(0, 9) == 0)
         return planned_ids[$urandom_range(0, planned_ids.size() - 1)];
      return rand_word();
   endfunction

   task automatic queue_random_item();
      int          pick;
      logic [1:0]  op;
      logic [63:0] id;
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = scs_pkg::FUNC_PUSH;
      else if (pick < 80) op = scs_pkg::FUNC_EMIT;
      else if (pick < 95) op = scs_pkg::FUNC_QUERY;
      else                op = FUNC_SPARE;
      id = (op == scs_pkg::FUNC_EMIT) ? pick_emit_id() : pick_push_id();
      queue_request(op, id, 8'($urandom_range(0, 255)), trace_word(), trace_word());
   endtask

   // Empty the stack, overfill it, query it, miss across all of it, then pop from the bottom.
   task automatic queue_fill_run();
      while (planned_ids.size() > 0)
         queue_request(scs_pkg::FUNC_EMIT, planned_ids[0], 8'($urandom_range(0, 255)),
                       rand_word(), rand_word());
      repeat (scs_pkg::STACK_DEPTH + 6)
         queue_request(scs_pkg::FUNC_PUSH, rand_word(), 8'($urandom_range(0, 255)),
                       trace_word(), trace_word());
      queue_request(scs_pkg::FUNC_QUERY, rand_word(), 8'($urandom_range(0, 255)),
                    rand_word(), rand_word());
      queue_request(scs_pkg::FUNC_EMIT, rand_word(), 8'($urandom_range(0, 255)),
                    rand_word(), rand_word());
      queue_request(scs_pkg::FUNC_EMIT, planned_ids[0], 8'($urandom_range(0, 255)),
                    rand_word(), rand_word());
   endtask

   task automatic write_csr(input logic [scs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Rewrite all five root registers; in the off and random settings, upper data bits of the narrow ones carry noise.
   task automatic load_root(input root_setting_type setting);
      logic [63:0] v, h, l, s, f;
      case (setting)
         ROOT_OFF: begin
            v = rand_word();  v[0] = 1'b0;
            h = rand_word();  l = rand_word();  s = rand_word();  f = rand_word();
         end
         ROOT_ONES: begin
            v = '1;  h = '1;  l = '1;  s = '1;  f = '1;
         end
         ROOT_ZEROS: begin
            v = 64'd1;  h = '0;  l = '0;  s = '0;  f = '0;
         end
         default: begin
            v = rand_word();  v[0] = 1'b1;
            h = rand_word();  l = rand_word();  s = rand_word();  f = rand_word();
         end
      endcase
      write_csr(scs_pkg::CSR_ROOT_THI,   h);
      write_csr(scs_pkg::CSR_ROOT_TLO,   l);
      write_csr(scs_pkg::CSR_ROOT_SPAN,  s);
      write_csr(scs_pkg::CSR_ROOT_FLAGS, f);
      write_csr(scs_pkg::CSR_ROOT_VALID, v);
      n_settings++;
   endtask

   // Hold off until every queued request has been answered.
   task automatic wait_drained();
      while (n_answered < n_queued) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      logic [scs_pkg::CSR_IDX_W-1:0] spare_idx;
      logic [63:0]                   dup_id;

      root_on  = 1'b0;
      root_thi = '0;
      root_tlo = '0;
      root_sid = '0;
      root_flg = '0;
      stack_n  = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, root cleared by reset: empty stack, no-parent push, parent from the top,
      // query without root, emit miss, emit at the bottom and at the top, unused selector.
      @(posedge clock);
      queue_request(scs_pkg::FUNC_QUERY, '0, '0, '0, '0);
      queue_request(FUNC_SPARE, '1, '1, '1, '1);
      queue_request(scs_pkg::FUNC_EMIT, 64'h0123_4567_89ab_cdef, 8'h00, '0, '0);
      queue_request(scs_pkg::FUNC_PUSH, '1, 8'hff, '1, '1);
      queue_request(scs_pkg::FUNC_PUSH, '0, 8'h00, '0, '0);
      queue_request(scs_pkg::FUNC_QUERY, '1, 8'hff, '1, '1);
      queue_request(scs_pkg::FUNC_PUSH, 64'h5a5a_a5a5_0f0f_f0f0, 8'h5a, rand_word(),
                    rand_word());
      queue_request(scs_pkg::FUNC_EMIT, 64'hfedc_ba98_7654_3210, 8'hff, '1, '1);
      queue_request(scs_pkg::FUNC_EMIT, '1, 8'h00, '0, '0);
      queue_request(scs_pkg::FUNC_PUSH, '0, 8'hff, '0, '0);
      queue_request(scs_pkg::FUNC_EMIT, '0, 8'hff, '1, '1);
      wait_drained();

      // Directed, root set to all ones: root as parent, duplicate ids, unused selector.
      load_root(ROOT_ONES);
      @(posedge clock);
      dup_id = rand_word();
      queue_request(scs_pkg::FUNC_QUERY, '0, '0, '0, '0);
      queue_request(scs_pkg::FUNC_PUSH, dup_id, 8'h00, '0, '0);
      queue_request(scs_pkg::FUNC_PUSH, dup_id, 8'h3c, rand_word(), rand_word());
      queue_request(scs_pkg::FUNC_QUERY, '0, '0, '0, '0);
      queue_request(scs_pkg::FUNC_EMIT, dup_id, '0, '0, '0);
      queue_request(FUNC_SPARE, '1, '1, '1, '1);
      queue_request(scs_pkg::FUNC_EMIT, dup_id, '1, '1, '1);
      wait_drained();

      // Random phases, each under its own root setting; the stack carries over.
      for (int p = 0; p < N_PHASES; p++) begin
         load_root(root_setting_type'(p % 4));
         if (p == 0) begin
            // unmapped register indexes must change nothing
            for (int k = scs_pkg::CSR_ROOT_FLAGS + 1; k < 2 ** scs_pkg::CSR_IDX_W; k++) begin
               spare_idx = k[scs_pkg::CSR_IDX_W-1:0];
               write_csr(spare_idx, rand_word());
            end
         end
         @(posedge clock);
         idle_on = (p % 4 != 3);   // every fourth phase runs both sides flat out
         if (p == 2 || p == 5) queue_fill_run();
         repeat (ITEMS_PER_PHASE) queue_random_item();
         wait_drained();           // sender pauses until every response is back
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d requests under %0d root settings in %0d cycles",
               n_accepted, n_settings, cycles);
      $display("Emits matched %0d, missed %0d; pushes refused on a full stack %0d",
               n_found, n_missed, n_refused);
      if (fail_count == 0 && expected_ctx_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
